// ===== src/background_autocrop_core_macros.svh =====
// Assertion macros for the background autocrop checker
`ifndef BACKGROUND_AUTOCROP_CORE_MACROS_SVH
`define BACKGROUND_AUTOCROP_CORE_MACROS_SVH

// implication checked on the same clock edge
`define BAC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked on the next clock edge
`define BAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bac_pkg.sv =====
// Types, constants and helper functions for the background autocrop core
package bac_pkg;

    localparam int FRAME_PIXELS = 65536;
    localparam int DIM_MAX      = 4096;

    localparam int PIX_W   = 32;
    localparam int DIM_W   = $clog2(DIM_MAX) + 1;
    localparam int POS_W   = DIM_W - 1;
    localparam int PROD_W  = 2 * DIM_W;
    localparam int ADDR_W  = $clog2(FRAME_PIXELS);
    localparam int CFG_IDX_W = 2;

    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = DIM_W'(256);
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = DIM_W'(256);

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_NO_READ = 2'd2,
        ST_OVERRUN = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_BACKGROUND   = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_MUL,
        S_EXEC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic addr;
        logic mul;
        logic exec;
        logic out_load;
    } t_cmd;

    // size register clamped to 1..DIM_MAX
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(DIM_MAX)) begin
            r = DIM_W'(DIM_MAX);
        end
        return r;
    endfunction

endpackage

// ===== src/background_autocrop_core.sv =====
// Top level of the background autocrop core
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-------------------------------
//  in       | input     | i_in_valid / o_in_stall    | i_operation, i_pixel_in
//  out      | output    | o_out_valid / i_out_stall  | o_pixel_out .. o_status
//  cfg      | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Transactions do not overlap: operand select, row-times-width multiply,
// frame store access, result capture, then back to idle, where the next input is taken.
// The single-port frame store takes at most one access per transaction.
// Synchronous active-low reset; no clearing pass, store contents undefined until loaded.
// A new input is accepted while the previous result waits in the output register;
// a result stalled at the output holds the sequencer in its final step.
module background_autocrop_core import bac_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_operation,
    input  logic [PIX_W-1:0]     i_pixel_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [PIX_W-1:0]     o_pixel_out,
    output logic                 o_last_pixel,
    output logic [POS_W-1:0]     o_crop_top,
    output logic [POS_W-1:0]     o_crop_left,
    output logic [DIM_W-1:0]     o_crop_width,
    output logic [DIM_W-1:0]     o_crop_height,
    output logic                 o_frame_complete,
    output logic [1:0]           o_status,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PIX_W-1:0]     i_cfg_data
);

    t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    bac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    bac_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_operation      (i_operation),
        .i_pixel_in       (i_pixel_in),
        .i_cfg_we         (i_cfg_valid & o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_pixel_out      (o_pixel_out),
        .o_last_pixel     (o_last_pixel),
        .o_crop_top       (o_crop_top),
        .o_crop_left      (o_crop_left),
        .o_crop_width     (o_crop_width),
        .o_crop_height    (o_crop_height),
        .o_frame_complete (o_frame_complete),
        .o_status         (o_status)
    );

endmodule

// ===== src/bac_ram.sv =====
// Generic single-port RAM with registered read
module bac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/bac_ctrl.sv =====
// Sequencing state machine and output handshake of the autocrop core
module bac_ctrl import bac_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: n_state = S_MUL;
            S_MUL:  n_state = S_EXEC;
            S_EXEC: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            S_ADDR: o_cmd.addr = 1'b1;
            S_MUL:  o_cmd.mul  = 1'b1;
            S_EXEC: o_cmd.exec = 1'b1;
            S_DONE: o_cmd.out_load = out_free;
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== src/bac_dp.sv =====
// Datapath: config registers, frame store, bounding box tracking and readout
module bac_dp import bac_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic                 i_operation,
    input  logic [PIX_W-1:0]     i_pixel_in,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PIX_W-1:0]     i_cfg_data,
    output logic [PIX_W-1:0]     o_pixel_out,
    output logic                 o_last_pixel,
    output logic [POS_W-1:0]     o_crop_top,
    output logic [POS_W-1:0]     o_crop_left,
    output logic [DIM_W-1:0]     o_crop_width,
    output logic [DIM_W-1:0]     o_crop_height,
    output logic                 o_frame_complete,
    output logic [1:0]           o_status
);

    // config
    logic [DIM_W-1:0]  r_img_w, r_img_h;
    logic [PIX_W-1:0]  r_bg;

    // tracked state
    logic [DIM_W-1:0]  r_load_row, n_load_row;
    logic [POS_W-1:0]  r_load_col, n_load_col;
    logic [POS_W-1:0]  r_min_row, n_min_row, r_max_row, n_max_row;
    logic [POS_W-1:0]  r_min_col, n_min_col, r_max_col, n_max_col;
    logic              r_found, n_found;
    logic              r_loaded, n_loaded;
    logic [POS_W-1:0]  r_read_row, n_read_row, r_read_col, n_read_col;

    // per-transaction stage registers
    t_op               r_op;
    logic [PIX_W-1:0]  r_pix;
    logic [DIM_W-1:0]  r_row_op;
    logic [POS_W-1:0]  r_col_op;
    logic [POS_W-1:0]  r_rr, r_rc;
    logic [PROD_W-1:0] r_prod;
    t_status           r_status, n_status;
    logic              r_last, n_last;
    logic              r_rd_hit, n_rd_hit;

    // result register
    logic [PIX_W-1:0]  r_pixel_out;
    logic              r_last_out;
    logic [POS_W-1:0]  r_top, r_left;
    logic [DIM_W-1:0]  r_cw, r_ch;
    logic              r_complete;
    t_status           r_status_out;

    logic [DIM_W-1:0]  eff_w, eff_h;
    logic [DIM_W-1:0]  crop_w, crop_h;
    logic [POS_W-1:0]  rr, rc;
    logic [DIM_W-1:0]  row_sum, col_sum;
    logic [DIM_W-1:0]  row_sel;
    logic [POS_W-1:0]  col_sel;
    logic [PROD_W-1:0] addr_sum;
    logic              in_store;
    logic              load_blocked;
    logic              is_fg;
    logic [POS_W-1:0]  load_row_pos;
    logic [DIM_W-1:0]  load_col_inc, load_row_inc;
    logic [DIM_W-1:0]  rc_inc, rr_inc;
    logic              ram_we, ram_re;
    logic [PIX_W-1:0]  ram_rdata;

    assign eff_w = eff_dim(r_img_w);
    assign eff_h = eff_dim(r_img_h);

    assign crop_w = r_found ? DIM_W'({1'b0, r_max_col} - {1'b0, r_min_col} + DIM_W'(1)) : '0;
    assign crop_h = r_found ? DIM_W'({1'b0, r_max_row} - {1'b0, r_min_row} + DIM_W'(1)) : '0;

    // operand select stage
    assign rr      = ({1'b0, r_read_row} >= crop_h) ? '0 : r_read_row;
    assign rc      = ({1'b0, r_read_col} >= crop_w) ? '0 : r_read_col;
    assign row_sum = {1'b0, r_min_row} + {1'b0, rr};
    assign col_sum = {1'b0, r_min_col} + {1'b0, rc};
    assign row_sel = (r_op == OP_LOAD) ? r_load_row : row_sum;
    assign col_sel = (r_op == OP_LOAD) ? r_load_col : col_sum[POS_W-1:0];

    // store access stage
    assign addr_sum     = r_prod + PROD_W'(r_col_op);
    assign in_store     = addr_sum < PROD_W'(FRAME_PIXELS);
    assign load_blocked = r_loaded || (r_load_row >= eff_h);
    assign is_fg        = r_pix != r_bg;
    assign load_row_pos = r_load_row[POS_W-1:0];
    assign load_col_inc = {1'b0, r_load_col} + DIM_W'(1);
    assign load_row_inc = r_load_row + DIM_W'(1);
    assign rc_inc       = {1'b0, r_rc} + DIM_W'(1);
    assign rr_inc       = {1'b0, r_rr} + DIM_W'(1);

    always_comb begin
        n_load_row = r_load_row;
        n_load_col = r_load_col;
        n_min_row  = r_min_row;
        n_max_row  = r_max_row;
        n_min_col  = r_min_col;
        n_max_col  = r_max_col;
        n_found    = r_found;
        n_loaded   = r_loaded;
        n_read_row = r_read_row;
        n_read_col = r_read_col;
        n_status   = ST_OK;
        n_last     = 1'b0;
        n_rd_hit   = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        if (i_cmd.exec) begin
            if (r_op == OP_LOAD) begin
                if (load_blocked) begin
                    n_loaded = 1'b1;
                    n_status = ST_OVERRUN;
                end else begin
                    if (in_store) begin
                        ram_we = 1'b1;
                    end else begin
                        n_status = ST_OVERRUN;
                    end
                    if (is_fg) begin
                        if (!r_found) begin
                            n_min_row = load_row_pos;
                            n_max_row = load_row_pos;
                            n_min_col = r_load_col;
                            n_max_col = r_load_col;
                            n_found   = 1'b1;
                        end else begin
                            if (load_row_pos < r_min_row) n_min_row = load_row_pos;
                            if (load_row_pos > r_max_row) n_max_row = load_row_pos;
                            if (r_load_col < r_min_col)   n_min_col = r_load_col;
                            if (r_load_col > r_max_col)   n_max_col = r_load_col;
                        end
                    end
                    if (load_col_inc >= eff_w) begin
                        n_load_col = '0;
                        n_load_row = load_row_inc;
                        if (load_row_inc >= eff_h) begin
                            n_loaded = 1'b1;
                        end
                    end else begin
                        n_load_col = load_col_inc[POS_W-1:0];
                    end
                    if (n_status == ST_OK && n_loaded && !n_found) begin
                        n_status = ST_EMPTY;
                    end
                end
            end else begin
                if (!r_loaded) begin
                    n_status = ST_NO_READ;
                end else if (!r_found) begin
                    n_status = ST_EMPTY;
                end else begin
                    ram_re   = in_store;
                    n_rd_hit = in_store;
                    if (rc_inc >= crop_w) begin
                        n_read_col = '0;
                        if (rr_inc >= crop_h) begin
                            n_read_row = '0;
                            n_last     = 1'b1;
                        end else begin
                            n_read_row = rr_inc[POS_W-1:0];
                        end
                    end else begin
                        n_read_col = rc_inc[POS_W-1:0];
                        n_read_row = r_rr;
                    end
                end
            end
        end
    end

    bac_ram #(
        .WIDTH (PIX_W),
        .DEPTH (FRAME_PIXELS)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (addr_sum[ADDR_W-1:0]),
        .i_wdata (r_pix),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w    <= RST_IMAGE_WIDTH;
            r_img_h    <= RST_IMAGE_HEIGHT;
            r_bg       <= '0;
            r_load_row <= '0;
            r_load_col <= '0;
            r_min_row  <= '1;
            r_max_row  <= '0;
            r_min_col  <= '1;
            r_max_col  <= '0;
            r_found    <= 1'b0;
            r_loaded   <= 1'b0;
            r_read_row <= '0;
            r_read_col <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_IMAGE_WIDTH:  r_img_w <= i_cfg_data[DIM_W-1:0];
                    CFG_IMAGE_HEIGHT: r_img_h <= i_cfg_data[DIM_W-1:0];
                    CFG_BACKGROUND:   r_bg    <= i_cfg_data;
                    default: ;
                endcase
            end
            r_load_row <= n_load_row;
            r_load_col <= n_load_col;
            r_min_row  <= n_min_row;
            r_max_row  <= n_max_row;
            r_min_col  <= n_min_col;
            r_max_col  <= n_max_col;
            r_found    <= n_found;
            r_loaded   <= n_loaded;
            r_read_row <= n_read_row;
            r_read_col <= n_read_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= t_op'(i_operation);
            r_pix <= i_pixel_in;
        end
        if (i_cmd.addr) begin
            r_row_op <= row_sel;
            r_col_op <= col_sel;
            r_rr     <= rr;
            r_rc     <= rc;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_row_op) * PROD_W'(eff_w);
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_last   <= n_last;
            r_rd_hit <= n_rd_hit;
        end
        if (i_cmd.out_load) begin
            r_pixel_out  <= r_rd_hit ? ram_rdata : '0;
            r_last_out   <= r_last;
            r_top        <= r_found ? r_min_row : '0;
            r_left       <= r_found ? r_min_col : '0;
            r_cw         <= crop_w;
            r_ch         <= crop_h;
            r_complete   <= r_loaded;
            r_status_out <= r_status;
        end
    end

    assign o_pixel_out      = r_pixel_out;
    assign o_last_pixel     = r_last_out;
    assign o_crop_top       = r_top;
    assign o_crop_left      = r_left;
    assign o_crop_width     = r_cw;
    assign o_crop_height    = r_ch;
    assign o_frame_complete = r_complete;
    assign o_status         = r_status_out;

endmodule

// ===== src/bac_checker.sv =====
// Port-level assertions for the background autocrop core, bound to the top level
`include "background_autocrop_core_macros.svh"

module bac_checker import bac_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [PIX_W-1:0] o_pixel_out,
    input logic             o_last_pixel,
    input logic [DIM_W-1:0] o_crop_width,
    input logic [DIM_W-1:0] o_crop_height,
    input logic             o_frame_complete,
    input logic [1:0]       o_status
);

    logic last_ok;
    logic box_even;

    assign last_ok  = (o_status == ST_OK) && o_frame_complete;
    assign box_even = (o_crop_width == '0) == (o_crop_height == '0);

    `BAC_ASSERT_NEXT(a_out_valid_held, o_out_valid && i_out_stall, o_out_valid, "valid dropped")
    `BAC_ASSERT_NEXT(a_pix_held, o_out_valid && i_out_stall, $stable(o_pixel_out), "pixel moved")
    `BAC_ASSERT_NEXT(a_one_in_flight, i_in_valid && !o_in_stall, o_in_stall, "taken while busy")
    `BAC_ASSERT_NOW(a_last_ok, o_out_valid && o_last_pixel, last_ok, "bad last")
    `BAC_ASSERT_NOW(a_box_both_empty, o_out_valid, box_even, "box half empty")

endmodule

bind background_autocrop_core bac_checker u_bac_checker (.*);

// ===== tb/sv/tb_background_autocrop_core.sv =====
// Testbench for background_autocrop_core: frame load and cropped readout against a predictor
module tb_background_autocrop_core;
    import bac_pkg::*;

    localparam int TOTAL_ITEMS  = 1050;
    localparam int STUCK_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
        logic [POS_W-1:0] top;
        logic [POS_W-1:0] left;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             complete;
        t_status          status;
    } t_crop_beat;

    class t_crop_tracker;
        logic [DIM_W-1:0] width_reg;
        logic [DIM_W-1:0] height_reg;
        logic [PIX_W-1:0] bg_reg;
        bit   [PIX_W-1:0] frame_mem [FRAME_PIXELS];
        int unsigned      load_row, load_col, read_row, read_col;
        int unsigned      top_row, bottom_row, left_col, right_col;
        bit               seen_fg, loaded;
        t_crop_beat       pending_crops [$];
        int unsigned      errors;

        function new();
            width_reg  = RST_IMAGE_WIDTH;
            height_reg = RST_IMAGE_HEIGHT;
            bg_reg     = '0;
            load_row   = 0;
            load_col   = 0;
            read_row   = 0;
            read_col   = 0;
            top_row    = 'hFFF;
            left_col   = 'hFFF;
            bottom_row = 0;
            right_col  = 0;
            seen_fg    = 1'b0;
            loaded     = 1'b0;
            errors     = 0;
        endfunction

        function int unsigned effective_size(logic [DIM_W-1:0] v);
            if (v == '0) return 1;
            if (v > DIM_MAX) return DIM_MAX;
            return v;
        endfunction

        function void write_register(t_cfg_idx idx, logic [PIX_W-1:0] data);
            case (idx)
                CFG_IMAGE_WIDTH: width_reg = data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg = data[DIM_W-1:0];
                CFG_BACKGROUND: bg_reg = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_crops.size();
        endfunction

        function void note_pixel_item(t_op op, logic [PIX_W-1:0] pix);
            int unsigned w, h, addr, cw, ch;
            t_crop_beat  beat;
            w = effective_size(width_reg);
            h = effective_size(height_reg);
            beat = '0;
            beat.status = ST_OK;
            cw = 0;
            ch = 0;
            if (seen_fg) begin
                cw = right_col - left_col + 1;
                ch = bottom_row - top_row + 1;
            end
            if (op == OP_LOAD) begin
                if (loaded || load_row >= h) begin
                    loaded = 1'b1;
                    beat.status = ST_OVERRUN;
                end else begin
                    addr = load_row * w + load_col;
                    if (addr < FRAME_PIXELS) begin
                        frame_mem[addr] = pix;
                    end else begin
                        beat.status = ST_OVERRUN;
                    end
                    if (pix != bg_reg) begin
                        if (!seen_fg) begin
                            top_row    = load_row;
                            bottom_row = load_row;
                            left_col   = load_col;
                            right_col  = load_col;
                            seen_fg    = 1'b1;
                        end else begin
                            if (load_row < top_row) top_row = load_row;
                            if (load_row > bottom_row) bottom_row = load_row;
                            if (load_col < left_col) left_col = load_col;
                            if (load_col > right_col) right_col = load_col;
                        end
                    end
                    if (load_col + 1 >= w) begin
                        load_col = 0;
                        load_row++;
                        if (load_row >= h) loaded = 1'b1;
                    end else begin
                        load_col++;
                    end
                    if (beat.status == ST_OK && loaded && !seen_fg) beat.status = ST_EMPTY;
                end
                if (seen_fg) begin
                    cw = right_col - left_col + 1;
                    ch = bottom_row - top_row + 1;
                end
            end else if (!loaded) begin
                beat.status = ST_NO_READ;
            end else if (!seen_fg) begin
                beat.status = ST_EMPTY;
            end else begin
                if (read_row >= ch) read_row = 0;
                if (read_col >= cw) read_col = 0;
                addr = (top_row + read_row) * w + left_col + read_col;
                if (addr < FRAME_PIXELS) beat.pixel = frame_mem[addr];
                if (read_col + 1 >= cw) begin
                    read_col = 0;
                    read_row++;
                    if (read_row >= ch) begin
                        read_row  = 0;
                        beat.last = 1'b1;
                    end
                end else begin
                    read_col++;
                end
            end
            beat.top      = seen_fg ? POS_W'(top_row) : '0;
            beat.left     = seen_fg ? POS_W'(left_col) : '0;
            beat.width    = DIM_W'(cw);
            beat.height   = DIM_W'(ch);
            beat.complete = loaded;
            pending_crops.push_back(beat);
        endfunction

        task report_mismatch(string what, logic [PIX_W-1:0] got, logic [PIX_W-1:0] want);
            errors++;
            $display("mismatch %0d: %s got %0h expected %0h", errors, what, got, want);
        endtask

        task check_crop_result(t_crop_beat got);
            t_crop_beat want;
            if (pending_crops.size() == 0) begin
                report_mismatch("unexpected transaction, pixel_out", got.pixel, '0);
                return;
            end
            want = pending_crops.pop_front();
            if (got.pixel !== want.pixel) report_mismatch("pixel_out", got.pixel, want.pixel);
            if (got.last !== want.last)
                report_mismatch("last_pixel", PIX_W'(got.last), PIX_W'(want.last));
            if (got.top !== want.top)
                report_mismatch("crop_top", PIX_W'(got.top), PIX_W'(want.top));
            if (got.left !== want.left)
                report_mismatch("crop_left", PIX_W'(got.left), PIX_W'(want.left));
            if (got.width !== want.width)
                report_mismatch("crop_width", PIX_W'(got.width), PIX_W'(want.width));
            if (got.height !== want.height)
                report_mismatch("crop_height", PIX_W'(got.height), PIX_W'(want.height));
            if (got.complete !== want.complete)
                report_mismatch("frame_complete", PIX_W'(got.complete), PIX_W'(want.complete));
            if (got.status !== want.status)
                report_mismatch("status", PIX_W'(got.status), PIX_W'(want.status));
        endtask
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 i_operation = 1'b0;
    logic [PIX_W-1:0]     i_pixel_in  = '0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [PIX_W-1:0]     i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [PIX_W-1:0]     o_pixel_out;
    logic                 o_last_pixel;
    logic [POS_W-1:0]     o_crop_top;
    logic [POS_W-1:0]     o_crop_left;
    logic [DIM_W-1:0]     o_crop_width;
    logic [DIM_W-1:0]     o_crop_height;
    logic                 o_frame_complete;
    logic [1:0]           o_status;
    logic                 o_cfg_ready;

    t_crop_tracker tracker = new();
    int unsigned items_sent = 0;

    background_autocrop_core u_dut (.*);

    always #10 i_clk = ~i_clk;

    // sender 13 / receiver 54 percent, then swapped, then no idling
    function automatic int unsigned idle_pct(bit sender);
        if (items_sent < TOTAL_ITEMS / 3) return sender ? 13 : 54;
        if (items_sent < 2 * TOTAL_ITEMS / 3) return sender ? 54 : 13;
        return 0;
    endfunction

    function automatic logic [PIX_W-1:0] size_word(int unsigned v);
        return ($urandom & 32'hFFFF_E000) | v;
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(logic [PIX_W-1:0] bgc, bit fg);
        logic [PIX_W-1:0] p;
        p = bgc;
        if (fg) begin
            p = $urandom;
            while (p == bgc) p = $urandom;
        end
        return p;
    endfunction

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < idle_pct(1'b0));
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_crop_result({o_pixel_out, o_last_pixel, o_crop_top, o_crop_left,
                                       o_crop_width, o_crop_height, o_frame_complete,
                                       o_status});
    end

    initial begin : watchdog
        int unsigned stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                stuck = 0;
            end else begin
                stuck++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic drop_input_and_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    task automatic send_pixel_item(t_op op, logic [PIX_W-1:0] pix);
        if ($urandom_range(99) < idle_pct(1'b1)) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_pixel_in  <= pix;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_pixel_item(op, pix);
        items_sent++;
    endtask

    task automatic write_config(t_cfg_idx idx, logic [PIX_W-1:0] data);
        drop_input_and_drain();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_register(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned      row_len, tail_len, fg15, fg16;
        logic [PIX_W-1:0] bg_tail, pix;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        send_pixel_item(OP_READ, 32'hFFFF_FFFF);
        send_pixel_item(OP_READ, 32'h0000_0000);

        // rows 0..14 one pixel wide, all background
        write_config(CFG_BACKGROUND, 32'hFFFF_FFFF);
        write_config(CFG_IMAGE_WIDTH, size_word(0));
        write_config(CFG_IMAGE_HEIGHT, size_word(32'h1FFF));
        for (int row = 0; row < 15; row++) begin
            if ($urandom_range(7) == 0) send_pixel_item(OP_READ, $urandom);
            send_pixel_item(OP_LOAD, 32'hFFFF_FFFF);
        end

        // row 15 at full width with zero as background
        row_len = $urandom_range(20, 60);
        fg15    = $urandom_range(0, row_len - 1);
        write_config(CFG_IMAGE_WIDTH, size_word(32'h1FFF));
        write_config(CFG_BACKGROUND, 32'h0000_0000);
        for (int col = 0; col < row_len; col++) begin
            pix = (col == fg15) ? 32'hFFFF_FFFF : pick_pixel(32'h0, 1'($urandom_range(1)));
            if ($urandom_range(9) == 0) send_pixel_item(OP_READ, $urandom);
            send_pixel_item(OP_LOAD, pix);
        end

        // narrowing the width wraps the load position to row 16
        write_config(CFG_IMAGE_WIDTH, size_word(1));
        send_pixel_item(OP_LOAD, 32'h0000_0000);

        // row 16 falls past the end of the store but still widens the box
        bg_tail  = $urandom | 32'h1;
        tail_len = $urandom_range(1, row_len);
        fg16     = $urandom_range(0, tail_len - 1);
        write_config(CFG_IMAGE_WIDTH, size_word(DIM_MAX));
        write_config(CFG_BACKGROUND, bg_tail);
        for (int col = 0; col < tail_len; col++) begin
            pix = (col == fg16) ? 32'h0000_0000 : pick_pixel(bg_tail, 1'($urandom_range(1)));
            send_pixel_item(OP_LOAD, pix);
        end

        // height below the load row closes the frame
        write_config(CFG_IMAGE_HEIGHT, size_word(0));
        send_pixel_item(OP_LOAD, $urandom);
        write_config(CFG_IMAGE_HEIGHT, size_word(DIM_MAX));

        while (items_sent < TOTAL_ITEMS) begin
            if (items_sent == TOTAL_ITEMS / 2) write_config(CFG_BACKGROUND, $urandom);
            send_pixel_item(($urandom_range(99) < 8) ? OP_LOAD : OP_READ, $urandom);
        end

        drop_input_and_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/bac_pkg.sv
src/bac_ram.sv
src/bac_ctrl.sv
src/bac_dp.sv
src/background_autocrop_core.sv
src/bac_checker.sv
tb/sv/tb_background_autocrop_core.sv
